/* sv/tpfmd_pkg.sv */
// Shared types and constants of the touch point filter, mapper and debouncer.
// Used by tpfmd_filter, tpfmd_axis and touch_point_filter_map_debounce_core.
// Has no dependencies of its own.
package tpfmd_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned PosW   = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Median values outside this window are treated as no contact.
  localparam logic [RawW-1:0] EdgeLow     = 16'd100;
  localparam logic [RawW-1:0] EdgeHigh    = 16'd4000;
  // Calibration span used when an axis has an empty range.
  localparam logic [RawW-1:0] DefaultSpan = 16'd4095;

  typedef enum logic [1:0] {
    EvPress   = 2'd0,
    EvRelease = 2'd1,
    EvMove    = 2'd2
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgXLow     = 3'd0,
    CfgXHigh    = 3'd1,
    CfgYLow     = 3'd2,
    CfgYHigh    = 3'd3,
    CfgSwap     = 3'd4,
    CfgMirrorX  = 3'd5,
    CfgMirrorY  = 3'd6,
    CfgResistive = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic            contact;
    logic [RawW-1:0] x_first;
    logic [RawW-1:0] x_second;
    logic [RawW-1:0] x_third;
    logic [RawW-1:0] y_first;
    logic [RawW-1:0] y_second;
    logic [RawW-1:0] y_third;
  } poll_t;

  typedef struct packed {
    logic            got;
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
  } point_t;

endpackage

/* sv/tpfmd_filter.sv */
// Point filter: median of three readings per axis and edge rejection in
// resistive mode, first reading otherwise. Depends on tpfmd_pkg.
module tpfmd_filter (
  input  tpfmd_pkg::poll_t  poll_i,
  input  logic              resistive_i,
  output tpfmd_pkg::point_t point_o
);

  function automatic logic [tpfmd_pkg::RawW-1:0] median3(
    input logic [tpfmd_pkg::RawW-1:0] a,
    input logic [tpfmd_pkg::RawW-1:0] b,
    input logic [tpfmd_pkg::RawW-1:0] c
  );
    logic [tpfmd_pkg::RawW-1:0] lo;
    logic [tpfmd_pkg::RawW-1:0] hi;
    logic [tpfmd_pkg::RawW-1:0] mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  logic [tpfmd_pkg::RawW-1:0] med_x;
  logic [tpfmd_pkg::RawW-1:0] med_y;
  logic                       in_window;
  logic                       got;

  always_comb begin
    med_x = median3(poll_i.x_first, poll_i.x_second, poll_i.x_third);
    med_y = median3(poll_i.y_first, poll_i.y_second, poll_i.y_third);
    in_window = (med_x >= tpfmd_pkg::EdgeLow) && (med_x <= tpfmd_pkg::EdgeHigh) &&
                (med_y >= tpfmd_pkg::EdgeLow) && (med_y <= tpfmd_pkg::EdgeHigh);
    got = poll_i.contact && (!resistive_i || in_window);

    point_o.got = got;
    if (!got) begin
      point_o.raw_x = '0;
      point_o.raw_y = '0;
    end else if (resistive_i) begin
      point_o.raw_x = med_x;
      point_o.raw_y = med_y;
    end else begin
      point_o.raw_x = poll_i.x_first;
      point_o.raw_y = poll_i.y_first;
    end
  end

endmodule

/* sv/tpfmd_axis.sv */
// Calibration scaler for one axis: (raw - low) * SIZE / (high - low) with
// truncation toward zero, by a bit-serial restoring divider. Depends on tpfmd_pkg.
module tpfmd_axis #(
  parameter int unsigned SIZE = 320
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [tpfmd_pkg::RawW-1:0]             raw_i,
  input  logic [tpfmd_pkg::RawW-1:0]             lo_i,
  input  logic [tpfmd_pkg::RawW-1:0]             hi_i,
  output logic                                   busy_o,
  output logic signed [tpfmd_pkg::RawW+$clog2(SIZE+1):0] value_o
);

  localparam int unsigned SW = $clog2(SIZE + 1);
  localparam int unsigned PW = tpfmd_pkg::RawW + SW;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned RW = tpfmd_pkg::RawW;

  logic          busy_q, busy_d;
  logic          mul_q, mul_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] num_q, num_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] den_q, den_d;
  logic          neg_q, neg_d;

  logic          empty;
  logic [RW-1:0] lo_eff;
  logic [RW-1:0] den_eff;
  logic          below;
  logic [RW-1:0] mag;
  logic [RW:0]   trial;
  logic [RW:0]   trial_sub;
  logic          fits;
  logic [PW:0]   q_ext;

  always_comb begin
    empty   = hi_i <= lo_i;
    lo_eff  = empty ? '0 : lo_i;
    den_eff = empty ? tpfmd_pkg::DefaultSpan : (hi_i - lo_i);
    below   = raw_i < lo_eff;
    mag     = below ? (lo_eff - raw_i) : (raw_i - lo_eff);

    // One quotient bit per cycle; the remainder always stays below the divisor.
    trial     = {rem_q, num_q[PW-1]};
    fits      = trial >= {1'b0, den_q};
    trial_sub = trial - {1'b0, den_q};

    busy_d = busy_q;
    mul_d  = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      mul_d  = 1'b1;
      num_d  = PW'(mag);
      den_d  = den_eff;
      neg_d  = below;
    end else if (mul_q) begin
      num_d = PW'(num_q[RW-1:0] * 32'(SIZE));
      rem_d = '0;
      cnt_d = CW'(PW);
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[RW-1:0] : trial[RW-1:0];
      num_d = {num_q[PW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      mul_q  <= mul_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign q_ext   = {1'b0, num_q};
  assign value_o = neg_q ? -$signed(q_ext) : $signed(q_ext);
  assign busy_o  = busy_q;

endmodule

/* sv/touch_point_filter_map_debounce_core.sv */
// Top level of the touch point filter, mapper and debouncer.
// Depends on tpfmd_pkg, tpfmd_filter and tpfmd_axis.
//
// Usage:
//   One input transaction is one panel poll (contact flag, three X and three
//   Y readings, poll time). It is accepted when in_valid_i is high and
//   in_stall_o is low. Each poll gives zero or one result transaction (press,
//   release or move) on the output channel, which is taken when out_valid_o
//   is high and out_stall_i is low. Configuration registers are written
//   through cfg_we_i, cfg_idx_i and cfg_wdata_i. The user must write them only
//   while no poll is in progress; the block itself does not enforce this.
//   Polls are processed one at a time. A touched poll passes through filter,
//   launch, the multiply step, the bit-serial division of both axes in
//   parallel, the check that both dividers are done, map, decide and the idle
//   state that accepts the next poll. A poll without a valid point goes from
//   filter straight to decide and then back to idle.
//   A result waits in the output register while the receiver stalls; the
//   next poll is accepted and processed meanwhile, and only its own result
//   waits for the register to free up.
//   Reset clears the touch state, last position and time, and loads the
//   calibration defaults (0..4095 on both axes, resistive mode on).
module touch_point_filter_map_debounce_core #(
  parameter int unsigned PANEL_WIDTH        = 320,
  parameter int unsigned PANEL_HEIGHT       = 240,
  parameter int unsigned DEBOUNCE_WINDOW_MS = 30
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpfmd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tpfmd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               contact_i,
  input  logic [tpfmd_pkg::RawW-1:0]         x_first_i,
  input  logic [tpfmd_pkg::RawW-1:0]         x_second_i,
  input  logic [tpfmd_pkg::RawW-1:0]         x_third_i,
  input  logic [tpfmd_pkg::RawW-1:0]         y_first_i,
  input  logic [tpfmd_pkg::RawW-1:0]         y_second_i,
  input  logic [tpfmd_pkg::RawW-1:0]         y_third_i,
  input  logic [tpfmd_pkg::TimeW-1:0]        now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         event_kind_o,
  output logic [tpfmd_pkg::PosW-1:0]         x_pos_o,
  output logic [tpfmd_pkg::PosW-1:0]         y_pos_o,
  output logic [tpfmd_pkg::RawW-1:0]         raw_x_o,
  output logic [tpfmd_pkg::RawW-1:0]         raw_y_o,
  output logic [tpfmd_pkg::TimeW-1:0]        event_time_ms_o
);

  localparam int unsigned RW  = tpfmd_pkg::RawW;
  localparam int unsigned PW  = tpfmd_pkg::PosW;
  localparam int unsigned TW  = tpfmd_pkg::TimeW;
  localparam int unsigned XPW = RW + $clog2(PANEL_WIDTH + 1);
  localparam int unsigned YPW = RW + $clog2(PANEL_HEIGHT + 1);
  localparam int unsigned VW  = ((XPW > YPW) ? XPW : YPW) + 2;

  localparam logic signed [VW-1:0] XSize = VW'(PANEL_WIDTH);
  localparam logic signed [VW-1:0] YSize = VW'(PANEL_HEIGHT);
  localparam logic signed [VW-1:0] XMax  = VW'(PANEL_WIDTH - 1);
  localparam logic signed [VW-1:0] YMax  = VW'(PANEL_HEIGHT - 1);
  localparam logic [PW-1:0]        XLast = PW'(PANEL_WIDTH - 1);
  localparam logic [PW-1:0]        YLast = PW'(PANEL_HEIGHT - 1);
  localparam logic [TW-1:0]        DebWin = TW'(DEBOUNCE_WINDOW_MS);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StFilter = 6'b000010,
    StLaunch = 6'b000100,
    StDivide = 6'b001000,
    StMap    = 6'b010000,
    StDecide = 6'b100000
  } state_e;

  // Configuration registers.
  logic [RW-1:0] cal_x_low_q, cal_x_high_q, cal_y_low_q, cal_y_high_q;
  logic          swap_q, mirror_x_q, mirror_y_q, resistive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_x_low_q  <= '0;
      cal_x_high_q <= tpfmd_pkg::DefaultSpan;
      cal_y_low_q  <= '0;
      cal_y_high_q <= tpfmd_pkg::DefaultSpan;
      swap_q       <= 1'b0;
      mirror_x_q   <= 1'b0;
      mirror_y_q   <= 1'b0;
      resistive_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (tpfmd_pkg::cfg_idx_e'(cfg_idx_i))
        tpfmd_pkg::CfgXLow:      cal_x_low_q  <= cfg_wdata_i;
        tpfmd_pkg::CfgXHigh:     cal_x_high_q <= cfg_wdata_i;
        tpfmd_pkg::CfgYLow:      cal_y_low_q  <= cfg_wdata_i;
        tpfmd_pkg::CfgYHigh:     cal_y_high_q <= cfg_wdata_i;
        tpfmd_pkg::CfgSwap:      swap_q       <= cfg_wdata_i[0];
        tpfmd_pkg::CfgMirrorX:   mirror_x_q   <= cfg_wdata_i[0];
        tpfmd_pkg::CfgMirrorY:   mirror_y_q   <= cfg_wdata_i[0];
        tpfmd_pkg::CfgResistive: resistive_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control and tracking state.
  state_e        state_q, state_d;
  logic          touch_down_q, touch_down_d;
  logic [TW-1:0] last_change_q, last_change_d;
  logic [PW-1:0] last_x_q, last_x_d;
  logic [PW-1:0] last_y_q, last_y_d;
  logic          out_valid_q, out_valid_d;

  // Per-poll working registers.
  tpfmd_pkg::poll_t  poll_q, poll_d;
  logic [TW-1:0]     now_q, now_d;
  tpfmd_pkg::point_t point_q, point_d;
  logic [PW-1:0]     px_q, px_d;
  logic [PW-1:0]     py_q, py_d;

  // Output register payload.
  logic [1:0]    kind_q, kind_d;
  logic [PW-1:0] out_x_q, out_x_d;
  logic [PW-1:0] out_y_q, out_y_d;
  logic [RW-1:0] out_rx_q, out_rx_d;
  logic [RW-1:0] out_ry_q, out_ry_d;
  logic [TW-1:0] out_t_q, out_t_d;

  tpfmd_pkg::point_t point_comb;
  logic              in_accept;
  logic              axis_start;
  logic              x_busy, y_busy;
  logic signed [XPW:0] x_val;
  logic signed [YPW:0] y_val;

  logic signed [VW-1:0] xv, yv, xs, ys, xm, ym;
  logic [PW-1:0]        px_clamp, py_clamp;

  logic          change;
  logic          in_window;
  logic          moved;
  logic          has_result;
  logic          out_free;
  logic [TW-1:0] elapsed;

  tpfmd_filter u_filter (
    .poll_i      (poll_q),
    .resistive_i (resistive_q),
    .point_o     (point_comb)
  );

  tpfmd_axis #(
    .SIZE (PANEL_WIDTH)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (axis_start),
    .raw_i   (point_q.raw_x),
    .lo_i    (cal_x_low_q),
    .hi_i    (cal_x_high_q),
    .busy_o  (x_busy),
    .value_o (x_val)
  );

  tpfmd_axis #(
    .SIZE (PANEL_HEIGHT)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (axis_start),
    .raw_i   (point_q.raw_y),
    .lo_i    (cal_y_low_q),
    .hi_i    (cal_y_high_q),
    .busy_o  (y_busy),
    .value_o (y_val)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign axis_start = (state_q == StLaunch);

  // Swap, mirror and clamp of the scaled position.
  always_comb begin
    xv = VW'(x_val);
    yv = VW'(y_val);
    xs = swap_q ? yv : xv;
    ys = swap_q ? xv : yv;
    xm = mirror_x_q ? (XMax - xs) : xs;
    ym = mirror_y_q ? (YMax - ys) : ys;
    if (xm < 0) begin
      px_clamp = '0;
    end else if (xm >= XSize) begin
      px_clamp = XLast;
    end else begin
      px_clamp = xm[PW-1:0];
    end
    if (ym < 0) begin
      py_clamp = '0;
    end else if (ym >= YSize) begin
      py_clamp = YLast;
    end else begin
      py_clamp = ym[PW-1:0];
    end
  end

  // Debounce and event decision.
  always_comb begin
    change     = point_q.got != touch_down_q;
    elapsed    = now_q - last_change_q;
    in_window  = elapsed < DebWin;
    moved      = point_q.got && ((px_q != last_x_q) || (py_q != last_y_q));
    has_result = change ? !in_window : moved;
    out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d       = state_q;
    touch_down_d  = touch_down_q;
    last_change_d = last_change_q;
    last_x_d      = last_x_q;
    last_y_d      = last_y_q;
    out_valid_d   = out_valid_q && out_stall_i;
    poll_d        = poll_q;
    now_d         = now_q;
    point_d       = point_q;
    px_d          = px_q;
    py_d          = py_q;
    kind_d        = kind_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_rx_d      = out_rx_q;
    out_ry_d      = out_ry_q;
    out_t_d       = out_t_q;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          poll_d.contact  = contact_i;
          poll_d.x_first  = x_first_i;
          poll_d.x_second = x_second_i;
          poll_d.x_third  = x_third_i;
          poll_d.y_first  = y_first_i;
          poll_d.y_second = y_second_i;
          poll_d.y_third  = y_third_i;
          now_d           = now_ms_i;
          state_d         = StFilter;
        end
      end
      StFilter: begin
        point_d = point_comb;
        state_d = point_comb.got ? StLaunch : StDecide;
      end
      StLaunch: begin
        state_d = StDivide;
      end
      StDivide: begin
        if (!x_busy && !y_busy) begin
          state_d = StMap;
        end
      end
      StMap: begin
        px_d    = px_clamp;
        py_d    = py_clamp;
        state_d = StDecide;
      end
      StDecide: begin
        if (!has_result) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_rx_d    = point_q.raw_x;
          out_ry_d    = point_q.raw_y;
          out_t_d     = now_q;
          if (change) begin
            touch_down_d  = point_q.got;
            last_change_d = now_q;
          end
          if (change && !point_q.got) begin
            kind_d  = tpfmd_pkg::EvRelease;
            out_x_d = last_x_q;
            out_y_d = last_y_q;
          end else begin
            kind_d   = change ? tpfmd_pkg::EvPress : tpfmd_pkg::EvMove;
            out_x_d  = px_q;
            out_y_d  = py_q;
            last_x_d = px_q;
            last_y_d = py_q;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      touch_down_q  <= 1'b0;
      last_change_q <= '0;
      last_x_q      <= '0;
      last_y_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      touch_down_q  <= touch_down_d;
      last_change_q <= last_change_d;
      last_x_q      <= last_x_d;
      last_y_q      <= last_y_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    poll_q   <= poll_d;
    now_q    <= now_d;
    point_q  <= point_d;
    px_q     <= px_d;
    py_q     <= py_d;
    kind_q   <= kind_d;
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    out_rx_q <= out_rx_d;
    out_ry_q <= out_ry_d;
    out_t_q  <= out_t_d;
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign x_pos_o         = out_x_q;
  assign y_pos_o         = out_y_q;
  assign raw_x_o         = out_rx_q;
  assign raw_y_o         = out_ry_q;
  assign event_time_ms_o = out_t_q;

  // The dividers are never running while the block waits for a new poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!x_busy && !y_busy))
    else $error("axis divider busy while idle");

  // A new touch is only recorded together with a press transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(touch_down_q) |-> (out_valid_o && (event_kind_o == tpfmd_pkg::EvPress)))
    else $error("touch recorded without a press transaction");

  // The remembered position always lies on the panel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, last_x_q} < 13'(PANEL_WIDTH)) && ({1'b0, last_y_q} < 13'(PANEL_HEIGHT)))
    else $error("last position outside the panel");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for touch_point_filter_map_debounce_core.
// Depends on tpfmd_pkg and the core RTL. Polls come from a directed table and from
// random touch sessions; every result is compared with a table entry or a behavioral model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PanelW        = 320;
  localparam int unsigned PanelH        = 240;
  localparam int unsigned DebounceMs    = 30;
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned ItemsPerPhase = 117;

  typedef struct packed {
    logic                             contact;
    logic [tpfmd_pkg::RawW-1:0]       x1, x2, x3, y1, y2, y3;
    logic [tpfmd_pkg::TimeW-1:0]      now;
  } poll_item_t;

  typedef struct packed {
    tpfmd_pkg::event_kind_e           kind;
    logic [tpfmd_pkg::PosW-1:0]       x, y;
    logic [tpfmd_pkg::RawW-1:0]       rx, ry;
    logic [tpfmd_pkg::TimeW-1:0]      t;
  } touch_event_t;

  typedef enum logic [1:0] {
    RowModel,
    RowQuiet,
    RowEvent
  } row_check_e;

  typedef struct packed {
    poll_item_t   poll;
    row_check_e   check;
    touch_event_t ev;
  } table_row_t;

  typedef struct packed {
    logic [tpfmd_pkg::RawW-1:0] xl, xh, yl, yh;
    logic                       swap, mx, my, res;
  } cal_set_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [tpfmd_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [tpfmd_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic                           contact_i   = 1'b0;
  logic [tpfmd_pkg::RawW-1:0]     x_first_i   = '0;
  logic [tpfmd_pkg::RawW-1:0]     x_second_i  = '0;
  logic [tpfmd_pkg::RawW-1:0]     x_third_i   = '0;
  logic [tpfmd_pkg::RawW-1:0]     y_first_i   = '0;
  logic [tpfmd_pkg::RawW-1:0]     y_second_i  = '0;
  logic [tpfmd_pkg::RawW-1:0]     y_third_i   = '0;
  logic [tpfmd_pkg::TimeW-1:0]    now_ms_i    = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [1:0]                     event_kind_o;
  logic [tpfmd_pkg::PosW-1:0]     x_pos_o;
  logic [tpfmd_pkg::PosW-1:0]     y_pos_o;
  logic [tpfmd_pkg::RawW-1:0]     raw_x_o;
  logic [tpfmd_pkg::RawW-1:0]     raw_y_o;
  logic [tpfmd_pkg::TimeW-1:0]    event_time_ms_o;

  // Model copy of the calibration registers and the touch state.
  logic [tpfmd_pkg::RawW-1:0]  cal_xl, cal_xh, cal_yl, cal_yh;
  logic                        cal_swap, cal_mx, cal_my, cal_res;
  logic                        touched;
  logic [tpfmd_pkg::TimeW-1:0] changed_at;
  logic [tpfmd_pkg::PosW-1:0]  shown_x, shown_y;
  logic [tpfmd_pkg::TimeW-1:0] poll_clock;

  touch_event_t pending_events[$];
  table_row_t   directed_rows[$];
  int unsigned  err_count    = 0;
  int unsigned  quiet_cycles = 0;

  touch_point_filter_map_debounce_core #(
    .PANEL_WIDTH       (PanelW),
    .PANEL_HEIGHT      (PanelH),
    .DEBOUNCE_WINDOW_MS(DebounceMs)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .contact_i      (contact_i),
    .x_first_i      (x_first_i),
    .x_second_i     (x_second_i),
    .x_third_i      (x_third_i),
    .y_first_i      (y_first_i),
    .y_second_i     (y_second_i),
    .y_third_i      (y_third_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .x_pos_o        (x_pos_o),
    .y_pos_o        (y_pos_o),
    .raw_x_o        (raw_x_o),
    .raw_y_o        (raw_y_o),
    .event_time_ms_o(event_time_ms_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [tpfmd_pkg::RawW-1:0] mid3(
    input logic [tpfmd_pkg::RawW-1:0] a, b, c);
    logic [tpfmd_pkg::RawW-1:0] t;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    return b;
  endfunction

  function automatic longint map_axis(input logic [tpfmd_pkg::RawW-1:0] raw, lo, hi,
                                      input longint span);
    longint l, h;
    l = lo;
    h = hi;
    if (hi <= lo) begin
      l = 0;
      h = tpfmd_pkg::DefaultSpan;
    end
    // Signed division in SystemVerilog truncates toward zero.
    return ((longint'(raw) - l) * span) / (h - l);
  endfunction

  function automatic logic [tpfmd_pkg::PosW-1:0] fit_axis(input longint v, input longint span);
    if (v < 0) v = 0;
    if (v >= span) v = span - 1;
    return v[tpfmd_pkg::PosW-1:0];
  endfunction

  // Advances the touch state by one poll and tells whether a result is due.
  function automatic bit track_touch(input poll_item_t p, output touch_event_t ev);
    logic [tpfmd_pkg::RawW-1:0] rx, ry;
    logic [tpfmd_pkg::PosW-1:0] px, py;
    longint                     xv, yv, t;
    bit                         got;
    rx  = '0;
    ry  = '0;
    px  = '0;
    py  = '0;
    got = 1'b0;
    ev  = '0;
    ev.t = p.now;
    if (p.contact) begin
      if (cal_res) begin
        rx  = mid3(p.x1, p.x2, p.x3);
        ry  = mid3(p.y1, p.y2, p.y3);
        got = rx >= tpfmd_pkg::EdgeLow && rx <= tpfmd_pkg::EdgeHigh &&
              ry >= tpfmd_pkg::EdgeLow && ry <= tpfmd_pkg::EdgeHigh;
      end else begin
        rx  = p.x1;
        ry  = p.y1;
        got = 1'b1;
      end
    end
    if (got) begin
      xv = map_axis(rx, cal_xl, cal_xh, PanelW);
      yv = map_axis(ry, cal_yl, cal_yh, PanelH);
      if (cal_swap) begin t = xv; xv = yv; yv = t; end
      if (cal_mx) xv = longint'(PanelW) - 1 - xv;
      if (cal_my) yv = longint'(PanelH) - 1 - yv;
      px = fit_axis(xv, PanelW);
      py = fit_axis(yv, PanelH);
    end else begin
      rx = '0;
      ry = '0;
    end
    if (got != touched) begin
      // A change inside the debounce window is dropped without touching the state.
      if (p.now - changed_at < DebounceMs) return 1'b0;
      touched    = got;
      changed_at = p.now;
      if (got) begin
        shown_x = px;
        shown_y = py;
        ev.kind = tpfmd_pkg::EvPress;
      end else begin
        ev.kind = tpfmd_pkg::EvRelease;
      end
      ev.x  = shown_x;
      ev.y  = shown_y;
      ev.rx = rx;
      ev.ry = ry;
      return 1'b1;
    end
    if (got && (px != shown_x || py != shown_y)) begin
      shown_x = px;
      shown_y = py;
      ev.kind = tpfmd_pkg::EvMove;
      ev.x    = px;
      ev.y    = py;
      ev.rx   = rx;
      ev.ry   = ry;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic table_row_t row(input logic c,
                                     input logic [tpfmd_pkg::RawW-1:0] x1, x2, x3,
                                     input logic [tpfmd_pkg::RawW-1:0] y1, y2, y3,
                                     input logic [tpfmd_pkg::TimeW-1:0] now,
                                     input row_check_e check,
                                     input tpfmd_pkg::event_kind_e kind = tpfmd_pkg::EvMove,
                                     input logic [tpfmd_pkg::PosW-1:0] px = '0, py = '0,
                                     input logic [tpfmd_pkg::RawW-1:0] rx = '0, ry = '0);
    table_row_t r;
    r.poll  = '{c, x1, x2, x3, y1, y2, y3, now};
    r.check = check;
    r.ev    = '{kind, px, py, rx, ry, now};
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [tpfmd_pkg::RawW-1:0] jitter(input logic [tpfmd_pkg::RawW-1:0] c,
                                                        input int unsigned amp);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * amp)) - int'(amp);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[tpfmd_pkg::RawW-1:0];
  endfunction

  function automatic logic [tpfmd_pkg::RawW-1:0] pick_center();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return tpfmd_pkg::RawW'($urandom_range(100, 4000));
    if (r < 80) return tpfmd_pkg::RawW'($urandom_range(85, 115));
    if (r < 90) return tpfmd_pkg::RawW'($urandom_range(3985, 4015));
    return tpfmd_pkg::RawW'($urandom);
  endfunction

  // Three readings around a point, now and then with one wild reading among them.
  function automatic poll_item_t make_poll(input logic contact,
                                           input logic [tpfmd_pkg::RawW-1:0] cx, cy,
                                           input logic [tpfmd_pkg::TimeW-1:0] now);
    poll_item_t p;
    p.contact = contact;
    p.x1 = jitter(cx, 6);
    p.x2 = jitter(cx, 6);
    p.x3 = jitter(cx, 6);
    p.y1 = jitter(cy, 6);
    p.y2 = jitter(cy, 6);
    p.y3 = jitter(cy, 6);
    p.now = now;
    case ($urandom_range(0, 5))
      0: p.x1 = tpfmd_pkg::RawW'($urandom);
      1: p.x3 = tpfmd_pkg::RawW'($urandom);
      2: p.y2 = tpfmd_pkg::RawW'($urandom);
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_poll(input poll_item_t p, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    contact_i  <= p.contact;
    x_first_i  <= p.x1;
    x_second_i <= p.x2;
    x_third_i  <= p.x3;
    y_first_i  <= p.y1;
    y_second_i <= p.y2;
    y_third_i  <= p.y3;
    now_ms_i   <= p.now;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic feed(input poll_item_t p, input bit steady);
    touch_event_t ev;
    send_poll(p, pick_gap(steady));
    if (track_touch(p, ev)) pending_events.push_back(ev);
  endtask

  task automatic write_reg(input tpfmd_pkg::cfg_idx_e idx,
                           input logic [tpfmd_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      tpfmd_pkg::CfgXLow:      cal_xl   = val;
      tpfmd_pkg::CfgXHigh:     cal_xh   = val;
      tpfmd_pkg::CfgYLow:      cal_yl   = val;
      tpfmd_pkg::CfgYHigh:     cal_yh   = val;
      tpfmd_pkg::CfgSwap:      cal_swap = val[0];
      tpfmd_pkg::CfgMirrorX:   cal_mx   = val[0];
      tpfmd_pkg::CfgMirrorY:   cal_my   = val[0];
      tpfmd_pkg::CfgResistive: cal_res  = val[0];
      default: ;
    endcase
  endtask

  task automatic load_cal(input cal_set_t c);
    logic [tpfmd_pkg::CfgDataW-1:0] pad;
    // Flag registers only look at bit 0, so the upper bits carry noise.
    pad = tpfmd_pkg::CfgDataW'($urandom);
    write_reg(tpfmd_pkg::CfgXLow, c.xl);
    write_reg(tpfmd_pkg::CfgXHigh, c.xh);
    write_reg(tpfmd_pkg::CfgYLow, c.yl);
    write_reg(tpfmd_pkg::CfgYHigh, c.yh);
    write_reg(tpfmd_pkg::CfgSwap, {pad[tpfmd_pkg::CfgDataW-1:1], c.swap});
    write_reg(tpfmd_pkg::CfgMirrorX, {~pad[tpfmd_pkg::CfgDataW-1:1], c.mx});
    write_reg(tpfmd_pkg::CfgMirrorY, {pad[tpfmd_pkg::CfgDataW-1:1], c.my});
    write_reg(tpfmd_pkg::CfgResistive, {~pad[tpfmd_pkg::CfgDataW-1:1], c.res});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result is out and a poll without a result has finished too.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed touch sessions (press, moves, release), the rest random polls.
  task automatic run_sessions(input int unsigned quota);
    int unsigned sent, moves;
    logic [tpfmd_pkg::RawW-1:0] cx, cy;
    poll_item_t noise;
    bit steady;
    sent = 0;
    case ($urandom_range(0, 3))
      0: poll_clock = $urandom;
      1: poll_clock = 32'hFFFF_FF00 | tpfmd_pkg::TimeW'($urandom_range(0, 255));
      default: ;
    endcase
    while (sent < quota) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 75) begin
        cx = pick_center();
        cy = pick_center();
        poll_clock += $urandom_range(20, 60);
        feed(make_poll(1'b1, cx, cy, poll_clock), steady);
        moves = $urandom_range(0, 8);
        repeat (moves) begin
          cx = jitter(cx, 40);
          cy = jitter(cy, 40);
          poll_clock += $urandom_range(0, 40);
          feed(make_poll(1'b1, cx, cy, poll_clock), steady);
        end
        poll_clock += $urandom_range(5, 60);
        if ($urandom_range(0, 3) == 0)
          feed(make_poll(1'b1, tpfmd_pkg::RawW'($urandom_range(4001, 65535)), cy,
                         poll_clock), steady);
        else
          feed(make_poll(1'b0, cx, cy, poll_clock), steady);
        sent += moves + 2;
      end else begin
        poll_clock += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 100);
        noise.contact = 1'($urandom_range(0, 1));
        noise.x1  = tpfmd_pkg::RawW'($urandom);
        noise.x2  = tpfmd_pkg::RawW'($urandom);
        noise.x3  = tpfmd_pkg::RawW'($urandom);
        noise.y1  = tpfmd_pkg::RawW'($urandom);
        noise.y2  = tpfmd_pkg::RawW'($urandom);
        noise.y3  = tpfmd_pkg::RawW'($urandom);
        noise.now = poll_clock;
        feed(noise, steady);
        sent++;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  initial begin : stimulus
    touch_event_t ev;
    bit           hit;
    cal_set_t     phase_cal[PhaseCount];

    cal_xl     = '0;
    cal_xh     = tpfmd_pkg::DefaultSpan;
    cal_yl     = '0;
    cal_yh     = tpfmd_pkg::DefaultSpan;
    cal_swap   = 1'b0;
    cal_mx     = 1'b0;
    cal_my     = 1'b0;
    cal_res    = 1'b1;
    touched    = 1'b0;
    changed_at = '0;
    shown_x    = '0;
    shown_y    = '0;
    poll_clock = 32'd1000;

    // Reset calibration, resistive mode: 2048 maps to 160,120, 100 to 7,5, 4000 to 312,234.
    directed_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 5, RowQuiet));
    directed_rows.push_back(row(1, 100, 4000, 2048, 2048, 2048, 2048, 10, RowQuiet));
    directed_rows.push_back(row(1, 2048, 100, 4000, 2048, 4000, 100, 40, RowEvent,
                                tpfmd_pkg::EvPress, 160, 120, 2048, 2048));
    directed_rows.push_back(row(1, 4000, 2048, 100, 100, 2048, 4000, 60, RowQuiet));
    directed_rows.push_back(row(1, 99, 99, 99, 2048, 2048, 2048, 65, RowQuiet));
    directed_rows.push_back(row(1, 99, 99, 99, 2048, 2048, 2048, 70, RowEvent,
                                tpfmd_pkg::EvRelease, 160, 120, 0, 0));
    directed_rows.push_back(row(1, 100, 100, 100, 4000, 4000, 4000, 100, RowEvent,
                                tpfmd_pkg::EvPress, 7, 234, 100, 4000));
    directed_rows.push_back(row(1, 4000, 4000, 65535, 0, 100, 100, 101, RowEvent,
                                tpfmd_pkg::EvMove, 312, 5, 4000, 100));
    directed_rows.push_back(row(1, 65535, 65535, 65535, 65535, 65535, 65535, 131, RowEvent,
                                tpfmd_pkg::EvRelease, 312, 5, 0, 0));
    directed_rows.push_back(row(0, 65535, 65535, 65535, 65535, 65535, 65535, 140, RowQuiet));
    directed_rows.push_back(row(1, 2000, 2001, 1999, 3000, 2999, 3001, 200, RowModel));
    directed_rows.push_back(row(1, 4001, 4001, 4001, 2000, 2000, 2000, 300, RowModel));
    directed_rows.push_back(row(1, 2000, 2000, 2000, 99, 99, 99, 400, RowModel));
    // The debounce distance is taken modulo 2^32 across the wrap of the poll time.
    directed_rows.push_back(row(1, 1000, 1000, 1000, 1000, 1000, 1000, 32'hFFFF_FFF0,
                                RowModel));
    directed_rows.push_back(row(1, 1200, 1201, 1199, 900, 901, 899, 32'hFFFF_FFFA, RowModel));
    directed_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 32'h0000_0005, RowModel));
    directed_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 32'h0000_000E, RowModel));
    directed_rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 32'h8000_0000, RowModel));
    directed_rows.push_back(row(1, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h00FF,
                                16'hFF00, 32'h5555_AAAA, RowModel));

    phase_cal[0] = '{16'd0, 16'd65535, 16'd0, 16'd65535, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_cal[1] = '{16'd200, 16'd3900, 16'd300, 16'd3800, 1'b1, 1'b1, 1'b1, 1'b1};
    // Empty ranges on both axes fall back to 0..4095.
    phase_cal[2] = '{16'd5000, 16'd5000, 16'd60000, 16'd100, 1'b0, 1'b0, 1'b1, 1'b0};
    phase_cal[3] = '{16'd0, 16'd1, 16'd65535, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1};
    phase_cal[4] = '{16'd1000, 16'd1500, 16'd2000, 16'd2100, 1'b0, 1'b1, 1'b1, 1'b0};
    phase_cal[5].xl   = tpfmd_pkg::RawW'($urandom_range(0, 2000));
    phase_cal[5].xh   = phase_cal[5].xl + tpfmd_pkg::RawW'($urandom_range(0, 3000));
    phase_cal[5].yl   = tpfmd_pkg::RawW'($urandom_range(0, 2000));
    phase_cal[5].yh   = phase_cal[5].yl + tpfmd_pkg::RawW'($urandom_range(0, 3000));
    phase_cal[5].swap = 1'($urandom_range(0, 1));
    phase_cal[5].mx   = 1'($urandom_range(0, 1));
    phase_cal[5].my   = 1'($urandom_range(0, 1));
    phase_cal[5].res  = 1'($urandom_range(0, 1));
    phase_cal[6]      = cal_set_t'({$urandom, $urandom, 4'($urandom)});
    phase_cal[7]      = '{16'd0, tpfmd_pkg::DefaultSpan, 16'd0, tpfmd_pkg::DefaultSpan,
                          1'b0, 1'b0, 1'b0, 1'b1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_poll(directed_rows[i].poll, pick_gap(1'b0));
      hit = track_touch(directed_rows[i].poll, ev);
      if (directed_rows[i].check == RowEvent) pending_events.push_back(directed_rows[i].ev);
      else if (directed_rows[i].check == RowModel && hit) pending_events.push_back(ev);
    end

    for (int k = 0; k < PhaseCount; k++) begin
      settle();
      load_cal(phase_cal[k]);
      run_sessions(ItemsPerPhase);
    end
    settle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver pacing: short stalls, a few long ones, and long stretches without any.
  initial begin : recv_pace
    int unsigned len, mode;
    logic        level;
    forever begin
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
        level = 1'b0;
        len   = $urandom_range(40, 120);
      end else if (mode < 15) begin
        level = 1'b1;
        len   = $urandom_range(15, 40);
      end else if (mode < 55) begin
        level = 1'b1;
        len   = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        len   = $urandom_range(1, 6);
      end
      repeat (len) begin
        out_stall_i <= level;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    touch_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result transaction: kind %0d x %0d y %0d time %0d",
               event_kind_o, x_pos_o, y_pos_o, event_time_ms_o);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, event_kind_o);
        check_field("x_pos", want.x, x_pos_o);
        check_field("y_pos", want.y, y_pos_o);
        check_field("raw_x", want.rx, raw_x_o);
        check_field("raw_y", want.ry, raw_y_o);
        check_field("event_time_ms", want.t, event_time_ms_o);
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
sv/tpfmd_pkg.sv
sv/tpfmd_filter.sv
sv/tpfmd_axis.sv
sv/touch_point_filter_map_debounce_core.sv
tb/sv/testbench.sv
